[sv/hdrv_pkg.sv]
// Shared types and constants for the three-channel haptic driver.
package hdrv_pkg;

    localparam int CHANNELS  = 3;
    localparam int BEND_W    = 10;
    localparam int MAG_W     = 10;
    localparam int DRIVE_W   = 8;
    localparam int CAL_W     = 9;
    localparam int DELAY_W   = 16;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Dividend is magnitude times full drive, which always fits in this width.
    localparam int DIVD_W    = MAG_W + DRIVE_W - 1;
    localparam int DIV_STEPS = DRIVE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int SH_W      = $clog2(DIV_STEPS);
    localparam int RAMP_W    = 9;

    localparam logic [DRIVE_W-1:0] FULL_DRIVE = 8'd255;
    localparam logic [RAMP_W-1:0]  RAMP_STEP  = 9'd10;
    localparam logic [RAMP_W-1:0]  RAMP_WRAP  = 9'd260;

    localparam logic [MODE_W-1:0] MODE_PROP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RAMP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONOFF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FULL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 3'd4;

    localparam logic [MODE_W-1:0]  RST_MODE  = MODE_PROP;
    localparam logic [CAL_W-1:0]   RST_CAL   = 9'd90;
    localparam logic [CAL_W-1:0]   RST_DEAD  = 9'd20;
    localparam logic [CAL_W-1:0]   RST_BAND  = 9'd35;
    localparam logic [DELAY_W-1:0] RST_DELAY = 16'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_HOLD
    } hdrv_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CAL_W-1:0]  cal;
        logic [CAL_W-1:0]  dead;
        logic [CAL_W-1:0]  band;
    } lane_cfg_t;

    typedef struct packed {
        logic               start;
        logic               commit;
        logic               fire;
        logic [DRIVE_W-1:0] ramp_level;
    } lane_ctrl_t;

endpackage

[sv/hdrv_lane.sv]
// One drive channel: magnitude, eight-step divider, debounce and drive level.
module hdrv_lane #(
    parameter int DEBOUNCE_COUNT = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hdrv_pkg::lane_ctrl_t         ctrl,
    input  hdrv_pkg::lane_cfg_t          cfg,
    input  logic [hdrv_pkg::BEND_W-1:0]  bend,
    output logic                         done,
    output logic [hdrv_pkg::DRIVE_W-1:0] drive
);
    import hdrv_pkg::*;

    localparam int CW = $clog2(DEBOUNCE_COUNT + 1);

    logic [MAG_W-1:0]   mag_in, mag_reg, mag_next;
    logic [DIVD_W-1:0]  rem_reg, rem_next, dividend, div_sh;
    logic [DRIVE_W-1:0] q_reg, q_next, drive_reg, drive_next, prop_level;
    logic               sat_reg, sat_next, busy_reg, busy_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next, sh_full;
    logic [SH_W-1:0]    sh;
    logic [CW-1:0]      dcnt_reg, dcnt_next, dcnt_upd;
    logic [CW:0]        dcnt_inc;
    logic               trig_reg, trig_next, trig_upd, oob;

    always_comb begin
        mag_in   = bend[BEND_W-1] ? MAG_W'(~bend + 1'b1) : MAG_W'(bend);
        dividend = DIVD_W'({mag_reg, DRIVE_W'(0)} - (MAG_W + DRIVE_W)'(mag_reg));
        sh_full  = STEP_W'(DIV_STEPS) - cnt_reg;
        sh       = sh_full[SH_W-1:0];
        div_sh   = DIVD_W'(cfg.cal) << sh;

        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;

        if (ctrl.start) begin
            mag_next  = mag_in;
            cnt_next  = '0;
            busy_next = 1'b1;
            q_next    = '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                // First step prepares the dividend and spots a quotient above full drive.
                rem_next = dividend;
                sat_next = dividend >= DIVD_W'({cfg.cal, DRIVE_W'(0)});
                cnt_next = cnt_reg + 1'b1;
            end else begin
                if (rem_reg >= div_sh) begin
                    rem_next   = rem_reg - div_sh;
                    q_next[sh] = 1'b1;
                end
                if (cnt_reg == STEP_W'(DIV_STEPS)) begin
                    busy_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        oob      = mag_reg > MAG_W'(cfg.band);
        dcnt_inc = {1'b0, dcnt_reg} + 1'b1;
        dcnt_upd = dcnt_reg;
        trig_upd = trig_reg;
        if (oob) begin
            if (dcnt_inc >= (CW + 1)'(DEBOUNCE_COUNT)) begin
                trig_upd = 1'b1;
                dcnt_upd = CW'(DEBOUNCE_COUNT - 1);
            end else begin
                dcnt_upd = dcnt_inc[CW-1:0];
            end
        end else if (dcnt_reg != '0) begin
            dcnt_upd = dcnt_reg - 1'b1;
        end else begin
            trig_upd = 1'b0;
        end

        if (mag_reg <= MAG_W'(cfg.dead)) begin
            prop_level = '0;
        end else if (sat_reg) begin
            prop_level = FULL_DRIVE;
        end else begin
            prop_level = q_reg;
        end

        dcnt_next  = dcnt_reg;
        trig_next  = trig_reg;
        drive_next = drive_reg;
        if (ctrl.commit) begin
            case (cfg.mode)
                MODE_PROP: begin
                    drive_next = prop_level;
                end
                MODE_RAMP: begin
                    dcnt_next = dcnt_upd;
                    trig_next = trig_upd;
                    if (ctrl.fire) begin
                        drive_next = trig_upd ? ctrl.ramp_level : '0;
                    end
                end
                MODE_ONOFF: begin
                    drive_next = oob ? FULL_DRIVE : '0;
                end
                MODE_FULL: begin
                    drive_next = FULL_DRIVE;
                end
                default: begin
                    drive_next = drive_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            drive_reg <= '0;
            dcnt_reg  <= '0;
            trig_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            drive_reg <= drive_next;
            dcnt_reg  <= dcnt_next;
            trig_reg  <= trig_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done  = !busy_reg;
    assign drive = drive_reg;

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= STEP_W'(DIV_STEPS))
        else $error("divider step count out of range");

    a_debounce_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW + 1)'(dcnt_reg) < (CW + 1)'(DEBOUNCE_COUNT))
        else $error("debounce count reached its trigger value");

    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> !busy_reg && !ctrl.start)
        else $error("levels committed while the divider was running");

endmodule

[sv/hdrv_ramp.sv]
// Shared ramp level and pulse timer for the debounced ramp mode.
module hdrv_ramp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         commit,
    input  logic [hdrv_pkg::TIME_W-1:0]  now_ms,
    input  logic [hdrv_pkg::MODE_W-1:0]  mode,
    input  logic [hdrv_pkg::DELAY_W-1:0] pulse_delay_ms,
    output logic                         fire,
    output logic [hdrv_pkg::DRIVE_W-1:0] ramp_level
);
    import hdrv_pkg::*;

    logic [TIME_W-1:0] now_reg, now_next, last_reg, last_next, elapsed;
    logic [RAMP_W-1:0] ramp_reg, ramp_next, ramp_sum;

    always_comb begin
        // Elapsed time wraps with the millisecond counter.
        elapsed  = now_reg - last_reg;
        fire     = (mode == MODE_RAMP) && (elapsed > TIME_W'(pulse_delay_ms));
        ramp_sum = ramp_reg + RAMP_STEP;

        now_next  = start ? now_ms : now_reg;
        last_next = last_reg;
        ramp_next = ramp_reg;
        if (commit && fire) begin
            last_next = now_reg;
            ramp_next = (ramp_sum >= RAMP_WRAP) ? '0 : ramp_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            ramp_reg <= '0;
        end else begin
            last_reg <= last_next;
            ramp_reg <= ramp_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg <= now_next;
    end

    assign ramp_level = ramp_reg[DRIVE_W-1:0];

endmodule

[sv/three_channel_haptic_driver.sv]
// Top level of the three-channel haptic driver: handshakes, configuration and lane control.
//
// Each input item carries three signed bend angles and the current millisecond time;
// each item gives exactly one result item holding the three PWM drive levels.
// The input channel (s_valid/s_ready) takes an item only when the block is idle. The
// three channel lanes then work side by side: each finds the bend magnitude and runs
// an eight-step restoring divider for the proportional level, one quotient bit per
// cycle, so the divider sets the pace. When all lanes are done the new levels,
// debounce counters and the shared ramp state are updated together and the result
// is offered on m_valid/m_ready.
// A result is offered once all lanes are done and the output side is free; no new item is
// taken before that. The block returns to idle as soon as the result is committed, so the
// next item may be accepted while that result still waits.
// If the receiver stalls, the finished levels are held until the previous result has
// been taken, and no further item is accepted meanwhile.
// Reset (aresetn low, synchronous) clears all drive levels, debounce counters,
// triggered flags, the ramp level and the pulse timestamp, and reloads the registers
// with mode 1, calibration 90, dead zone 20, band 35 and pulse delay 100 ms.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and are
// expected only while the block is idle.
module three_channel_haptic_driver #(
    parameter int DEBOUNCE_COUNT = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [hdrv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hdrv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [hdrv_pkg::BEND_W-1:0] s_bend_a,
    input  logic signed [hdrv_pkg::BEND_W-1:0] s_bend_b,
    input  logic signed [hdrv_pkg::BEND_W-1:0] s_bend_c,
    input  logic [hdrv_pkg::TIME_W-1:0]     s_now_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hdrv_pkg::DRIVE_W-1:0]    m_drive_a,
    output logic [hdrv_pkg::DRIVE_W-1:0]    m_drive_b,
    output logic [hdrv_pkg::DRIVE_W-1:0]    m_drive_c
);
    import hdrv_pkg::*;

    hdrv_state_t state_reg, state_next;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [CAL_W-1:0]   cal_reg, cal_next, dead_reg, dead_next, band_reg, band_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic               m_valid_reg, m_valid_next;

    logic               accept, commit, out_free, all_done, fire;
    logic [DRIVE_W-1:0] ramp_level;
    logic [CHANNELS-1:0] lane_done;
    logic [BEND_W-1:0]  bend_arr [CHANNELS];
    logic [DRIVE_W-1:0] drive_arr [CHANNELS];
    lane_cfg_t          lane_cfg;
    lane_ctrl_t         lane_ctrl;

    // Configuration registers; the index selects one, the data is cut to its width.
    always_comb begin
        mode_next  = mode_reg;
        cal_next   = cal_reg;
        dead_next  = dead_reg;
        band_next  = band_reg;
        delay_next = delay_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:  mode_next  = cfg_wdata[MODE_W-1:0];
                CFG_CAL:   cal_next   = cfg_wdata[CAL_W-1:0];
                CFG_DEAD:  dead_next  = cfg_wdata[CAL_W-1:0];
                CFG_BAND:  band_next  = cfg_wdata[CAL_W-1:0];
                CFG_DELAY: delay_next = cfg_wdata[DELAY_W-1:0];
                default:   mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= RST_MODE;
            cal_reg   <= RST_CAL;
            dead_reg  <= RST_DEAD;
            band_reg  <= RST_BAND;
            delay_reg <= RST_DELAY;
        end else begin
            mode_reg  <= mode_next;
            cal_reg   <= cal_next;
            dead_reg  <= dead_next;
            band_reg  <= band_next;
            delay_reg <= delay_next;
        end
    end

    // The output side is free when no result is waiting or the waiting one leaves now.
    assign out_free = !m_valid_reg || m_ready;
    assign all_done = &lane_done;
    assign accept   = s_valid && s_ready;

    // Next-state logic of the item sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (all_done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the item sequencer.
    always_comb begin
        s_ready = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CALC: begin
                commit = all_done && out_free;
            end
            ST_HOLD: begin
                commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign lane_cfg = '{mode: mode_reg, cal: cal_reg, dead: dead_reg, band: band_reg};
    assign lane_ctrl = '{start: accept, commit: commit, fire: fire, ramp_level: ramp_level};

    assign bend_arr[0] = s_bend_a;
    assign bend_arr[1] = s_bend_b;
    assign bend_arr[2] = s_bend_c;

    hdrv_ramp u_ramp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (accept),
        .commit         (commit),
        .now_ms         (s_now_ms),
        .mode           (mode_reg),
        .pulse_delay_ms (delay_reg),
        .fire           (fire),
        .ramp_level     (ramp_level)
    );

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        hdrv_lane #(
            .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .cfg     (lane_cfg),
            .bend    (bend_arr[ch]),
            .done    (lane_done[ch]),
            .drive   (drive_arr[ch])
        );
    end

    // The lane drive registers change only on a commit, so they act as the output register.
    assign m_valid   = m_valid_reg;
    assign m_drive_a = drive_arr[0];
    assign m_drive_b = drive_arr[1];
    assign m_drive_c = drive_arr[2];

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready && !all_done)
        else $error("accepted item did not start the lanes");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(commit))
        else $error("result offered without a commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !commit)
        else $error("levels changed while a result was stalled");

endmodule
